// File: hw/rtl/iuc_pkg.sv
// Shared types for the interval union coverage block.
package iuc_pkg;

   // Operation broadcast to every cell of the interval chain in the same cycle.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MARK,
      CELL_MERGE,
      CELL_STRETCH,
      CELL_INSERT
   } cell_op_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_MERGE,
      ST_STRETCH,
      ST_INSERT,
      ST_REPLY
   } state_type;

   // Control that the sequencer sends along the chain.
   typedef struct packed {
      cell_op_type op;
      logic        table_full;
   } cell_ctl_type;

endpackage

// File: hw/rtl/interval_union_coverage_core.sv
// Top level of the interval union coverage block: sequencer, totals and the cell chain.
// Each segment becomes a closed interval that is folded into a sorted chain of
// interval cells. A transfer that inserts a new interval or is dropped because the table
// is full passes through the mark, merge and insert states before the reply. A transfer
// that overlaps stored intervals passes through mark, merge and stretch, and stays in merge
// while its run spans three or more marked cells, because the chain folds one neighbouring
// pair per cycle. busy falls in the cycle that carries the result, so a new segment may be
// accepted then. Results cannot be held off: each one appears on the rsp_ ports for exactly
// one cycle, marked by rsp_strobe.
module interval_union_coverage_core #(
   parameter int MAX_INTERVALS = 64,
   parameter int POS_WIDTH     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_start_pos,
   input  logic [15:0] req_seg_length,
   output logic        rsp_strobe,
   output logic [33:0] rsp_coverage,
   output logic [6:0]  rsp_interval_count,
   output logic        rsp_overflow
);
   import iuc_pkg::*;

   localparam int CNT_WIDTH = $clog2(MAX_INTERVALS + 1);
   localparam int SUM_RAW   = POS_WIDTH + 2 + $clog2(MAX_INTERVALS);
   localparam int SUM_WIDTH = (SUM_RAW > 35) ? SUM_RAW : 35;

   state_type              state_ff, state_in;
   logic [POS_WIDTH-1:0]   seg_start_ff, seg_start_in;
   logic [POS_WIDTH:0]     seg_end_ff, seg_end_in;
   logic [16:0]            seg_span_ff, seg_span_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [SUM_WIDTH-1:0]   total_ff, total_in;
   logic                   overflow_ff, overflow_in;
   logic [POS_WIDTH+31:0]  pos_wide;
   logic [CNT_WIDTH+6:0]   count_wide;
   logic                   accept;
   logic                   table_full;
   cell_ctl_type           ctl;

   logic [POS_WIDTH-1:0]   cell_start  [MAX_INTERVALS];
   logic [POS_WIDTH:0]     cell_end    [MAX_INTERVALS];
   logic                   cell_mark   [MAX_INTERVALS];
   logic                   cell_before [MAX_INTERVALS];
   logic                   cell_carry  [MAX_INTERVALS];
   logic                   cell_pair   [MAX_INTERVALS];
   logic                   cell_triple [MAX_INTERVALS];
   logic [POS_WIDTH:0]     cell_gap    [MAX_INTERVALS];
   logic [POS_WIDTH-1:0]   cell_sel_st [MAX_INTERVALS];
   logic [POS_WIDTH:0]     cell_sel_en [MAX_INTERVALS];

   logic                   any_mark, any_pair, any_triple;
   logic [POS_WIDTH:0]     gap_sum;
   logic [POS_WIDTH-1:0]   run_start, fold_start;
   logic [POS_WIDTH:0]     run_end, fold_end;

   assign accept     = start && !busy;
   assign table_full = count_ff == CNT_WIDTH'(MAX_INTERVALS);

   // Segment capture: only the low position bits take part.
   assign pos_wide     = (POS_WIDTH + 32)'(req_start_pos);
   assign seg_start_in = accept ? pos_wide[POS_WIDTH-1:0] : seg_start_ff;
   assign seg_end_in   = accept ? ({1'b0, pos_wide[POS_WIDTH-1:0]}
                                   + (POS_WIDTH + 1)'(req_seg_length)) : seg_end_ff;
   assign seg_span_in  = accept ? ({1'b0, req_seg_length} + 17'd1) : seg_span_ff;

   // Cell chain, each cell linked to both neighbours.
   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      logic [POS_WIDTH-1:0] p_start, n_start;
      logic [POS_WIDTH:0]   p_end, n_end;
      logic                 p_mark, p_before, c_in, n_mark, n_pair;

      if (i == 0) begin : g_first
         assign p_start  = '0;
         assign p_end    = '0;
         assign p_mark   = 1'b0;
         assign p_before = 1'b1;
         assign c_in     = 1'b0;
      end else begin : g_inner
         assign p_start  = cell_start[i-1];
         assign p_end    = cell_end[i-1];
         assign p_mark   = cell_mark[i-1];
         assign p_before = cell_before[i-1];
         assign c_in     = cell_carry[i-1];
      end

      if (i == MAX_INTERVALS - 1) begin : g_last
         assign n_start = '0;
         assign n_end   = '0;
         assign n_mark  = 1'b0;
         assign n_pair  = 1'b0;
      end else begin : g_body
         assign n_start = cell_start[i+1];
         assign n_end   = cell_end[i+1];
         assign n_mark  = cell_mark[i+1];
         assign n_pair  = cell_pair[i+1];
      end

      iuc_cell #(
         .INDEX     (i),
         .POS_WIDTH (POS_WIDTH),
         .CNT_WIDTH (CNT_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_start   (seg_start_ff),
         .new_end     (seg_end_ff),
         .count       (count_ff),
         .prev_start  (p_start),
         .prev_end    (p_end),
         .prev_mark   (p_mark),
         .prev_before (p_before),
         .carry_in    (c_in),
         .next_start  (n_start),
         .next_end    (n_end),
         .next_mark   (n_mark),
         .next_pair   (n_pair),
         .start_out   (cell_start[i]),
         .end_out     (cell_end[i]),
         .mark_out    (cell_mark[i]),
         .before_out  (cell_before[i]),
         .carry_out   (cell_carry[i]),
         .pair_out    (cell_pair[i]),
         .triple_out  (cell_triple[i]),
         .gap_out     (cell_gap[i]),
         .sel_start   (cell_sel_st[i]),
         .sel_end     (cell_sel_en[i])
      );
   end

   // Gather flags and the one-hot contributions of the chain.
   always_comb begin
      any_mark   = 1'b0;
      any_pair   = 1'b0;
      any_triple = 1'b0;
      gap_sum    = '0;
      run_start  = '0;
      run_end    = '0;
      for (int k = 0; k < MAX_INTERVALS; k++) begin
         any_mark   = any_mark | cell_mark[k];
         any_pair   = any_pair | cell_pair[k];
         any_triple = any_triple | cell_triple[k];
         gap_sum    = gap_sum | cell_gap[k];
         run_start  = run_start | cell_sel_st[k];
         run_end    = run_end | cell_sel_en[k];
      end
   end

   assign fold_start = (run_start < seg_start_ff) ? run_start : seg_start_ff;
   assign fold_end   = (run_end > seg_end_ff) ? run_end : seg_end_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_REPLY: state_in = start ? ST_MARK : ST_IDLE;
         ST_MARK: begin
            // Marks are written at this edge; decide on them next cycle.
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!any_mark) begin
               state_in = ST_INSERT;
            end else if (!any_pair) begin
               state_in = ST_STRETCH;
            end else if (!any_triple) begin
               state_in = ST_STRETCH;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_STRETCH: state_in = ST_REPLY;
         ST_INSERT:  state_in = ST_REPLY;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: chain operation and running totals.
   always_comb begin
      ctl.op         = CELL_HOLD;
      ctl.table_full = table_full;
      count_in       = count_ff;
      total_in       = total_ff;
      overflow_in    = overflow_ff;
      unique case (state_ff)
         ST_IDLE, ST_REPLY: begin
            if (start) begin
               overflow_in = 1'b0;
            end
         end
         ST_MARK: begin
            ctl.op = CELL_MARK;
         end
         ST_MERGE: begin
            if (any_pair) begin
               ctl.op   = CELL_MERGE;
               count_in = count_ff - 1'b1;
               total_in = total_ff + SUM_WIDTH'(gap_sum);
            end
         end
         ST_STRETCH: begin
            ctl.op   = CELL_STRETCH;
            total_in = total_ff + SUM_WIDTH'(run_start - fold_start)
                       + SUM_WIDTH'(fold_end - run_end);
         end
         ST_INSERT: begin
            ctl.op = CELL_INSERT;
            if (table_full) begin
               overflow_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               total_in = total_ff + SUM_WIDTH'(seg_span_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seg_start_ff <= seg_start_in;
      seg_end_ff   <= seg_end_in;
      seg_span_ff  <= seg_span_in;
      overflow_ff  <= overflow_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   // Result ports; coverage saturates at the top of its field.
   assign busy               = !((state_ff == ST_IDLE) || (state_ff == ST_REPLY));
   assign rsp_strobe         = state_ff == ST_REPLY;
   assign count_wide         = (CNT_WIDTH + 7)'(count_ff);
   assign rsp_interval_count = count_wide[6:0];
   assign rsp_coverage       = (|total_ff[SUM_WIDTH-1:34]) ? '1 : total_ff[33:0];
   assign rsp_overflow       = overflow_ff;

   // The table never holds more intervals than it has cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(MAX_INTERVALS))
      else $error("interval count beyond table size");

   // A dropped segment is reported only with a full table.
   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow) |-> table_full)
      else $error("overflow reported with free cells");

   // A fold of two neighbours needs at least two stored intervals.
   a_merge_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && any_pair) |-> count_ff >= CNT_WIDTH'(2))
      else $error("merge with fewer than two intervals");

   // Every fold removes exactly one interval.
   a_merge_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && any_pair) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("merge did not remove one interval");

endmodule

// File: hw/rtl/iuc_cell.sv
// One cell of the interval chain: holds one stored interval and its merge mark.
module iuc_cell #(
   parameter int INDEX     = 0,
   parameter int POS_WIDTH = 32,
   parameter int CNT_WIDTH = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  iuc_pkg::cell_ctl_type ctl,
   input  logic [POS_WIDTH-1:0]  new_start,
   input  logic [POS_WIDTH:0]    new_end,
   input  logic [CNT_WIDTH-1:0]  count,
   input  logic [POS_WIDTH-1:0]  prev_start,
   input  logic [POS_WIDTH:0]    prev_end,
   input  logic                  prev_mark,
   input  logic                  prev_before,
   input  logic                  carry_in,
   input  logic [POS_WIDTH-1:0]  next_start,
   input  logic [POS_WIDTH:0]    next_end,
   input  logic                  next_mark,
   input  logic                  next_pair,
   output logic [POS_WIDTH-1:0]  start_out,
   output logic [POS_WIDTH:0]    end_out,
   output logic                  mark_out,
   output logic                  before_out,
   output logic                  carry_out,
   output logic                  pair_out,
   output logic                  triple_out,
   output logic [POS_WIDTH:0]    gap_out,
   output logic [POS_WIDTH-1:0]  sel_start,
   output logic [POS_WIDTH:0]    sel_end
);
   import iuc_pkg::*;

   logic [POS_WIDTH-1:0] start_ff, start_in;
   logic [POS_WIDTH:0]   end_ff, end_in;
   logic                 mark_ff, mark_in;
   logic                 occupied;
   logic                 hit;
   logic                 absorb;
   logic [POS_WIDTH-1:0] min_start;
   logic [POS_WIDTH:0]   max_end;

   // The cell holds a live interval when its place lies below the count.
   assign occupied = CNT_WIDTH'(INDEX) < count;

   // Overlap and ordering against the new interval.
   assign hit        = occupied && (end_ff >= {1'b0, new_start})
                       && ({1'b0, start_ff} <= new_end);
   assign before_out = occupied && (end_ff < {1'b0, new_start});

   // The first marked cell of a run swallows its marked right neighbour.
   assign absorb     = mark_ff && !prev_mark && next_mark;
   assign carry_out  = carry_in || absorb;
   assign pair_out   = mark_ff && next_mark;
   assign triple_out = pair_out && next_pair;
   assign gap_out    = absorb ? ({1'b0, next_start} - end_ff - 1'b1) : '0;

   assign min_start = (start_ff < new_start) ? start_ff : new_start;
   assign max_end   = (end_ff > new_end) ? end_ff : new_end;
   assign sel_start = mark_ff ? start_ff : '0;
   assign sel_end   = mark_ff ? end_ff : '0;

   assign start_out = start_ff;
   assign end_out   = end_ff;
   assign mark_out  = mark_ff;

   // Next contents of the cell for each broadcast operation.
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      mark_in  = mark_ff;
      case (ctl.op)
         CELL_MARK: begin
            mark_in = hit;
         end
         CELL_MERGE: begin
            if (carry_in) begin
               start_in = next_start;
               end_in   = next_end;
               mark_in  = next_mark;
            end else if (absorb) begin
               end_in = next_end;
            end
         end
         CELL_STRETCH: begin
            if (mark_ff) begin
               start_in = min_start;
               end_in   = max_end;
            end
         end
         CELL_INSERT: begin
            if (!ctl.table_full && !before_out) begin
               if (prev_before) begin
                  start_in = new_start;
                  end_in   = new_end;
               end else begin
                  start_in = prev_start;
                  end_in   = prev_end;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

endmodule

// File: bench/tb_interval_union_coverage_core.sv
// Self-checking testbench for the interval union coverage core.
module tb_interval_union_coverage_core;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [33:0] COVERAGE_CEILING = 34'h3_FFFF_FFFF;

   typedef struct {
      logic [33:0] coverage;
      logic [6:0]  interval_count;
      logic        overflow;
   } coverage_report_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_start_pos;
   logic [15:0] req_seg_length;
   logic        rsp_strobe;
   logic [33:0] rsp_coverage;
   logic [6:0]  rsp_interval_count;
   logic        rsp_overflow;

   // Shadow copy of the interval table.
   logic [31:0] shadow_starts [TABLE_DEPTH];
   logic [32:0] shadow_ends [TABLE_DEPTH];
   int          shadow_count;

   coverage_report_type pending_reports[$];
   int error_count;
   int cycle_count;

   interval_union_coverage_core u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_start_pos      (req_start_pos),
      .req_seg_length     (req_seg_length),
      .rsp_strobe         (rsp_strobe),
      .rsp_coverage       (rsp_coverage),
      .rsp_interval_count (rsp_interval_count),
      .rsp_overflow       (rsp_overflow)
   );

   // Clock with a period of 12 units.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Fold one segment into the shadow table and return the expected report.
   function automatic coverage_report_type fold_segment(input logic [31:0] seg_start,
                                                        input logic [15:0] seg_len);
      coverage_report_type rep;
      logic [32:0] seg_end;
      logic [31:0] new_start;
      logic [32:0] new_end;
      logic [35:0] sum;
      int lo;
      int hi;
      int gone;
      seg_end = {1'b0, seg_start} + seg_len;
      rep.overflow = 1'b0;
      lo = 0;
      while (lo < shadow_count && shadow_ends[lo] < {1'b0, seg_start}) lo++;
      hi = lo;
      while (hi < shadow_count && {1'b0, shadow_starts[hi]} <= seg_end) hi++;
      if (hi > lo) begin
         new_start = (shadow_starts[lo] < seg_start) ? shadow_starts[lo] : seg_start;
         new_end = (shadow_ends[hi - 1] > seg_end) ? shadow_ends[hi - 1] : seg_end;
         gone = hi - lo - 1;
         shadow_starts[lo] = new_start;
         shadow_ends[lo] = new_end;
         for (int i = lo + 1; i + gone < shadow_count; i++) begin
            shadow_starts[i] = shadow_starts[i + gone];
            shadow_ends[i] = shadow_ends[i + gone];
         end
         shadow_count -= gone;
      end else if (shadow_count < TABLE_DEPTH) begin
         for (int i = shadow_count; i > lo; i--) begin
            shadow_starts[i] = shadow_starts[i - 1];
            shadow_ends[i] = shadow_ends[i - 1];
         end
         shadow_starts[lo] = seg_start;
         shadow_ends[lo] = seg_end;
         shadow_count++;
      end else begin
         rep.overflow = 1'b1;
      end
      // Sum the spans, saturating at the width of the coverage field.
      sum = '0;
      for (int i = 0; i < shadow_count; i++) begin
         sum += shadow_ends[i] - {1'b0, shadow_starts[i]} + 36'd1;
         if (sum > {2'b00, COVERAGE_CEILING}) sum = {2'b00, COVERAGE_CEILING};
      end
      rep.coverage = sum[33:0];
      rep.interval_count = shadow_count[6:0];
      return rep;
   endfunction

   task automatic report_mismatch(input string field, input logic [33:0] got,
                                  input logic [33:0] want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
      error_count++;
   endtask

   // Send one segment and hold it until the block takes the transfer.
   task automatic send_segment(input logic [31:0] seg_start, input logic [15:0] seg_len);
      @(negedge clock);
      req_start_pos <= seg_start;
      req_seg_length <= seg_len;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_reports.insert(pending_reports.size(), fold_segment(seg_start, seg_len));
   endtask

   // Leave the request line low for a number of cycles.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain_reports();
      pause_sender(1);
      wait (pending_reports.size() == 0);
   endtask

   // Compare every result with the oldest expected report.
   always @(posedge clock) begin
      coverage_report_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $display("unexpected result at %0t", $time);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_coverage !== want.coverage)
               report_mismatch("coverage", rsp_coverage, want.coverage);
            if (rsp_interval_count !== want.interval_count)
               report_mismatch("interval_count", 34'(rsp_interval_count),
                               34'(want.interval_count));
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", 34'(rsp_overflow), 34'(want.overflow));
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Extreme fields, zero length, shared end points and a multi-interval fold.
   task automatic test_edge_segments();
      send_segment(32'h0000_0000, 16'h0000);
      send_segment(32'hFFFF_FFFF, 16'hFFFF);
      send_segment(32'hFFFF_0000, 16'h0000);
      send_segment(32'h0000_0000, 16'h0000);
      send_segment(32'h0000_1000, 16'h0010);
      send_segment(32'h0000_1010, 16'h0005);
      send_segment(32'h0000_0FF0, 16'h0010);
      send_segment(32'h0000_2000, 16'h0001);
      send_segment(32'h0000_3000, 16'h0001);
      send_segment(32'h0000_4000, 16'h0001);
      send_segment(32'h0000_1800, 16'h2800);
      send_segment(32'h5555_5555, 16'hAAAA);
      send_segment(32'hAAAA_AAAA, 16'h5555);
      drain_reports();
   endtask

   // Fill the table, overflow it, merge while full, then fold a long run.
   task automatic test_full_table();
      int k;
      k = 0;
      while (shadow_count < TABLE_DEPTH) begin
         send_segment(32'h8000_0000 + k * 1000, 16'd10);
         k++;
      end
      send_segment(32'h7000_0000, 16'd3);
      send_segment(32'h8000_0000 + k * 1000 + 500, 16'd0);
      send_segment(32'h8000_0005, 16'd1000);
      send_segment(32'h8000_0000, 16'hFFFF);
      send_segment(32'h7000_0000, 16'd3);
      drain_reports();
   endtask

   // Bursts of random segments, mostly clustered so that merges and overflow recur.
   task automatic test_random_segments(input int item_total);
      logic [31:0] base;
      logic [31:0] seg_start;
      logic [15:0] seg_len;
      int sent;
      int burst;
      int mode;
      sent = 0;
      base = $urandom;
      while (sent < item_total) begin
         burst = $urandom_range(1, 24);
         if ($urandom_range(0, 9) == 0) base = $urandom;
         repeat (burst) begin
            mode = $urandom_range(0, 19);
            if (mode < 14) begin
               seg_start = base + $urandom_range(0, 200000);
               seg_len = 16'($urandom_range(0, 3000));
            end else if (mode < 17) begin
               seg_start = $urandom;
               seg_len = 16'($urandom);
            end else if (mode < 19) begin
               seg_start = base + $urandom_range(0, 400000);
               seg_len = 16'hFFFF;
            end else begin
               seg_start = $urandom;
               seg_len = 16'h0000;
            end
            send_segment(seg_start, seg_len);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
         if (sent > item_total / 2 && sent - burst <= item_total / 2) drain_reports();
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      shadow_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_start_pos = '0;
      req_seg_length = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_segments();
      test_full_table();
      test_random_segments(620);

      // Wait for the last results, then let the clock run on before the verdict.
      drain_reports();
      repeat (80) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/iuc_pkg.sv
hw/rtl/iuc_cell.sv
hw/rtl/interval_union_coverage_core.sv
bench/tb_interval_union_coverage_core.sv
